// ===== hdl/scpd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scpd_pkg
// Shared types, constants and helpers of the scanline palette pixel decoder.
// ----------------------------------------------------------------------------
package scpd_pkg;

  typedef enum logic [1:0] {
    OP_WRITE_COLOR = 2'd0,
    OP_LINE_START  = 2'd1,
    OP_PIXEL       = 2'd2
  } op_t;

  localparam int COLOR_W     = 12;
  localparam int PIXEL_W     = 24;
  localparam int NIBBLE_W    = 4;
  localparam int NUM_BANKS   = 4;
  localparam int BANK_DEPTH  = 64;
  localparam int BANK_AW     = $clog2(BANK_DEPTH);
  localparam int BANK_SEL_W  = $clog2(NUM_BANKS);

  localparam int CTRL_FOUR_BIT = 7;
  localparam int CTRL_FILL_BIT = 5;

  // Scaling a nibble by 17 is the same as repeating it in both halves of a byte.
  function automatic logic [PIXEL_W-1:0] expand_color(input logic [COLOR_W-1:0] c);
    logic [NIBBLE_W-1:0] r;
    logic [NIBBLE_W-1:0] g;
    logic [NIBBLE_W-1:0] b;
    r = c[3:0];
    g = c[7:4];
    b = c[11:8];
    return {r, r, g, g, b, b};
  endfunction

endpackage
`default_nettype wire

// ===== hdl/scpd_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scpd_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module scpd_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic      [WIDTH-1:0]         rd_data_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic      [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/scanline_palette_pixel_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scanline_palette_pixel_decoder
// Turns packed pixel bytes into four 24-bit RGB pixels through 16 palettes.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle, whatever its operation, unless a
// pixel word in the read stage is held by a stalled output. A pixel word passes
// through the palette read and the output registers. The palette store is
// split into four banks by slot quarter, each with two read ports, so that the
// four lookups of a four-colour byte and the two lookups of a sixteen-colour
// byte are all served by the same read. A colour write is visible to the
// very next pixel word. Palette entries that were never written read as
// arbitrary values.
module scanline_palette_pixel_decoder
  import scpd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          operation,
  input  wire logic [3:0]          palette_sel,
  input  wire logic [3:0]          color_index,
  input  wire logic [COLOR_W-1:0]  color_word,
  input  wire logic [7:0]          control_byte,
  input  wire logic [7:0]          pixel_byte,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic      [PIXEL_W-1:0]  pixel0,
  output logic      [PIXEL_W-1:0]  pixel1,
  output logic      [PIXEL_W-1:0]  pixel2,
  output logic      [PIXEL_W-1:0]  pixel3
);

  typedef struct packed {
    logic                  four;
    logic [BANK_SEL_W-1:0] hi_bank;
    logic [BANK_SEL_W-1:0] lo_bank;
  } s1_info_t;

  // Line state
  logic [3:0]          active_palette;
  logic                four_colour_mode;
  logic                fill_enable;
  logic [NIBBLE_W-1:0] held_index;

  // Read stage
  logic     s1_valid;
  s1_info_t s1_info;
  s1_info_t s1_info_next;
  logic     s1_move;
  logic     out_four;

  logic in_accept;
  logic wr_accept;
  logic line_accept;
  logic pix_accept;
  op_t  op;

  logic [NIBBLE_W-1:0] hi_nib;
  logic [NIBBLE_W-1:0] lo_nib;

  logic [BANK_AW-1:0] rd_addr_a [NUM_BANKS];
  logic [BANK_AW-1:0] rd_addr_b [NUM_BANKS];
  logic [COLOR_W-1:0] rd_data_a [NUM_BANKS];
  logic [COLOR_W-1:0] rd_data_b [NUM_BANKS];

  assign op          = op_t'(operation);
  assign s1_move     = !out_valid || out_ready;
  assign in_ready    = !s1_valid || s1_move;
  assign in_accept   = in_valid && in_ready;
  assign wr_accept   = in_accept && (op == OP_WRITE_COLOR);
  assign line_accept = in_accept && (op == OP_LINE_START);
  assign pix_accept  = in_accept && (op == OP_PIXEL);

  // In fill mode a zero nibble repeats the last one used; the high nibble's
  // result is what the low nibble falls back on.
  always_comb begin
    hi_nib = pixel_byte[7:4];
    if (fill_enable && (pixel_byte[7:4] == '0)) begin
      hi_nib = held_index;
    end
    lo_nib = pixel_byte[3:0];
    if (fill_enable && (pixel_byte[3:0] == '0)) begin
      lo_nib = hi_nib;
    end
  end

  always_comb begin
    s1_info_next.four    = four_colour_mode;
    s1_info_next.hi_bank = hi_nib[3:2];
    s1_info_next.lo_bank = lo_nib[3:2];
  end

  genvar b;
  generate
    for (b = 0; b < NUM_BANKS; b++) begin : g_bank
      logic bank_wr_en;

      assign bank_wr_en = wr_accept && (color_index[3:2] == BANK_SEL_W'(b));
      assign rd_addr_a[b] = four_colour_mode ?
                            {active_palette, pixel_byte[7-2*b -: 2]} :
                            {active_palette, hi_nib[1:0]};
      assign rd_addr_b[b] = {active_palette, lo_nib[1:0]};

      scpd_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (BANK_DEPTH)
      ) u_bank (
        .clk       (clk),
        .wr_en     (bank_wr_en),
        .wr_addr   ({palette_sel, color_index[1:0]}),
        .wr_data   (color_word),
        .rd_en     (pix_accept),
        .rd_addr_a (rd_addr_a[b]),
        .rd_data_a (rd_data_a[b]),
        .rd_addr_b (rd_addr_b[b]),
        .rd_data_b (rd_data_b[b])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      active_palette   <= '0;
      four_colour_mode <= 1'b0;
      fill_enable      <= 1'b0;
      held_index       <= '0;
    end else if (line_accept) begin
      active_palette   <= control_byte[3:0];
      four_colour_mode <= control_byte[CTRL_FOUR_BIT];
      fill_enable      <= control_byte[CTRL_FILL_BIT];
      held_index       <= '0;
    end else if (pix_accept && !four_colour_mode) begin
      held_index <= lo_nib;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= pix_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      s1_info <= s1_info_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid) begin
      out_four <= s1_info.four;
      if (s1_info.four) begin
        pixel0 <= expand_color(rd_data_a[0]);
        pixel1 <= expand_color(rd_data_a[1]);
        pixel2 <= expand_color(rd_data_a[2]);
        pixel3 <= expand_color(rd_data_a[3]);
      end else begin
        pixel0 <= expand_color(rd_data_a[s1_info.hi_bank]);
        pixel1 <= expand_color(rd_data_a[s1_info.hi_bank]);
        pixel2 <= expand_color(rd_data_b[s1_info.lo_bank]);
        pixel3 <= expand_color(rd_data_b[s1_info.lo_bank]);
      end
    end
  end

  // The read data must not be overwritten while it waits for the output register.
  a_read_held : assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while the read stage was stalled");

  a_pix_to_stage : assert property (@(posedge clk) disable iff (rst)
    pix_accept |=> s1_valid)
    else $error("pixel word lost before the read stage");

  a_empty_ready : assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input stalled with an empty read stage");

  a_line_clear : assert property (@(posedge clk) disable iff (rst)
    line_accept |=> (held_index == '0))
    else $error("fill index not cleared at line start");

  a_pairs : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_four |-> (pixel0 == pixel1) && (pixel2 == pixel3))
    else $error("sixteen-colour pixels not doubled");

endmodule
`default_nettype wire
